/* rtl/core/mwm_pkg.sv */
`default_nettype none
package mwm_pkg;

  localparam int unsigned SPEED_W = 8;
  localparam int unsigned MIX_W = 10;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned DEADBAND_W = 5;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [MIX_W-1:0] mix_t;

  // Wheel speed limit and scale base (percent)
  localparam logic signed [MIX_W-1:0] SPEED_LIMIT = 10'sd100;
  localparam logic [8:0] PERCENT_FULL = 9'd100;
  localparam logic [DEADBAND_W-1:0] DEADBAND_MAX = 5'd30;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 5'd8;

  // floor(n/100) == (n * 20972) >> 21 for all n < 2^14
  localparam logic [14:0] DIV100_RECIP = 15'd20972;
  localparam int unsigned DIV100_SHIFT = 21;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INVERT_MASK = 1'b0,
    CFG_DEADBAND    = 1'b1
  } cfg_index_t;

endpackage
`default_nettype wire

/* rtl/core/mwm_cmd_if.sv */
`default_nettype none
interface mwm_cmd_if;
  logic valid;
  logic ready;
  mwm_pkg::speed_t strafe;
  mwm_pkg::speed_t forward;
  mwm_pkg::speed_t rotate;

  modport source (output valid, input ready, output strafe, output forward, output rotate);
  modport sink (input valid, output ready, input strafe, input forward, input rotate);
endinterface
`default_nettype wire

/* rtl/core/mwm_wheel_if.sv */
`default_nettype none
interface mwm_wheel_if;
  logic valid;
  logic ready;
  mwm_pkg::speed_t wheel0_speed;
  mwm_pkg::speed_t wheel1_speed;
  mwm_pkg::speed_t wheel2_speed;
  mwm_pkg::speed_t wheel3_speed;

  modport source (output valid, input ready, output wheel0_speed, output wheel1_speed,
                  output wheel2_speed, output wheel3_speed);
  modport sink (input valid, output ready, input wheel0_speed, input wheel1_speed,
                input wheel2_speed, input wheel3_speed);
endinterface
`default_nettype wire

/* rtl/core/mwm_cfg_if.sv */
`default_nettype none
interface mwm_cfg_if;
  logic valid;
  logic ready;
  mwm_pkg::cfg_index_t index;
  logic [mwm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, input ready, output index, output data);
  modport sink (input valid, output ready, input index, input data);
endinterface
`default_nettype wire

/* rtl/core/mecanum_wheel_mixer.sv */
`default_nettype none
// Channel  Dir  Payload
// cmd      in   strafe, forward, rotate (signed percent)
// wheel    out  wheel0_speed .. wheel3_speed (signed percent)
// cfg      in   index (0 invert mask, 1 deadband), data
//
// Three-stage pipeline: scale multiply, divide by 100 (reciprocal multiply),
// mix/clamp/finish into the output register. One command per cycle when wheel
// does not stall; a stall on wheel backs up stage by stage; bubbles are filled.
// Synchronous reset clears the stage valids and loads the register defaults.
// cmd and cfg are held not ready during reset; cfg is otherwise always ready.
module mecanum_wheel_mixer (
  input  wire logic    clk,
  input  wire logic    rst,
  mwm_cmd_if.sink      cmd,
  mwm_wheel_if.source  wheel,
  mwm_cfg_if.sink      cfg
);

  logic [mwm_pkg::MASK_W-1:0] invert_mask;
  logic [mwm_pkg::DEADBAND_W-1:0] deadband;

  logic v1, v2, v3;
  logic r1, r2, r3;

  // stage 1: scaled products
  logic signed [15:0] prod_x, prod_y;
  mwm_pkg::speed_t rot1;
  // stage 2: quotients
  logic signed [8:0] quot_x, quot_y;
  mwm_pkg::speed_t rot2;
  // stage 3: results
  mwm_pkg::speed_t speed0, speed1, speed2, speed3;

  logic [8:0] rot_abs;
  logic signed [8:0] scale;
  logic signed [16:0] mul_x, mul_y;
  logic [13:0] mag_x, mag_y;
  logic [28:0] recip_x, recip_y;
  logic [8:0] q_x, q_y;
  mwm_pkg::mix_t mx, my, mz;
  mwm_pkg::speed_t c0, c1, c2, c3;

  function automatic mwm_pkg::speed_t clamp_speed(input mwm_pkg::mix_t v);
    mwm_pkg::speed_t res;
    if (v > mwm_pkg::SPEED_LIMIT) begin
      res = mwm_pkg::SPEED_LIMIT[mwm_pkg::SPEED_W-1:0];
    end else if (v < -mwm_pkg::SPEED_LIMIT) begin
      res = mwm_pkg::speed_t'(-mwm_pkg::SPEED_LIMIT);
    end else begin
      res = v[mwm_pkg::SPEED_W-1:0];
    end
    return res;
  endfunction

  function automatic mwm_pkg::speed_t finish_wheel(input mwm_pkg::speed_t v, input logic inv,
                                                   input logic [mwm_pkg::DEADBAND_W-1:0] db);
    mwm_pkg::speed_t vi;
    logic [mwm_pkg::SPEED_W-1:0] mag;
    vi = inv ? -v : v;
    mag = vi[mwm_pkg::SPEED_W-1] ? -vi : vi;
    return (mag < {{(mwm_pkg::SPEED_W-mwm_pkg::DEADBAND_W){1'b0}}, db}) ? '0 : vi;
  endfunction

  assign r3 = !v3 || wheel.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign cmd.ready = r1 && !rst;
  assign cfg.ready = !rst;

  // scale factor 100 - |z|; with z == 0 it is 100 and the divide is exact
  always_comb begin
    rot_abs = cmd.rotate[mwm_pkg::SPEED_W-1] ? 9'(-$signed({cmd.rotate[7], cmd.rotate}))
                                             : 9'({1'b0, cmd.rotate});
    scale = $signed(mwm_pkg::PERCENT_FULL - rot_abs);
    mul_x = 17'($signed({cmd.strafe[7], cmd.strafe})) * 17'(scale);
    mul_y = 17'($signed({cmd.forward[7], cmd.forward})) * 17'(scale);
  end

  // truncating divide by 100 on the magnitude
  always_comb begin
    mag_x = prod_x[15] ? 14'(-prod_x) : prod_x[13:0];
    mag_y = prod_y[15] ? 14'(-prod_y) : prod_y[13:0];
    recip_x = {15'd0, mag_x} * {14'd0, mwm_pkg::DIV100_RECIP};
    recip_y = {15'd0, mag_y} * {14'd0, mwm_pkg::DIV100_RECIP};
    q_x = {1'b0, recip_x[28:mwm_pkg::DIV100_SHIFT]};
    q_y = {1'b0, recip_y[28:mwm_pkg::DIV100_SHIFT]};
  end

  always_comb begin
    mx = mwm_pkg::mix_t'(quot_x);
    my = mwm_pkg::mix_t'(quot_y);
    mz = mwm_pkg::mix_t'(rot2);
    c0 = clamp_speed(my + mx - mz);
    c1 = clamp_speed(my - mx + mz);
    c2 = clamp_speed(my - mx - mz);
    c3 = clamp_speed(my + mx + mz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      invert_mask <= '0;
      deadband <= mwm_pkg::DEADBAND_RESET;
    end else begin
      if (r1) v1 <= cmd.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (cfg.valid) begin
        unique case (cfg.index)
          mwm_pkg::CFG_INVERT_MASK: invert_mask <= cfg.data[mwm_pkg::MASK_W-1:0];
          mwm_pkg::CFG_DEADBAND: deadband <= (cfg.data > mwm_pkg::DEADBAND_MAX)
                                             ? mwm_pkg::DEADBAND_MAX : cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && cmd.valid) begin
      prod_x <= mul_x[15:0];
      prod_y <= mul_y[15:0];
      rot1 <= cmd.rotate;
    end
    if (r2 && v1) begin
      quot_x <= prod_x[15] ? -$signed(q_x) : $signed(q_x);
      quot_y <= prod_y[15] ? -$signed(q_y) : $signed(q_y);
      rot2 <= rot1;
    end
    if (r3 && v2) begin
      speed0 <= finish_wheel(c0, invert_mask[0], deadband);
      speed1 <= finish_wheel(c1, invert_mask[1], deadband);
      speed2 <= finish_wheel(c2, invert_mask[2], deadband);
      speed3 <= finish_wheel(c3, invert_mask[3], deadband);
    end
  end

  assign wheel.valid = v3;
  assign wheel.wheel0_speed = speed0;
  assign wheel.wheel1_speed = speed1;
  assign wheel.wheel2_speed = speed2;
  assign wheel.wheel3_speed = speed3;

endmodule
`default_nettype wire
